// ===== src/rsss_pkg.sv =====
// Shared types, constants and helpers for the rolling-sum substring search.
// No dependencies; every other file in src refers to this package by scope.
package rsss_pkg;

    localparam int PATTERN_BYTES   = 32;  // bytes held by the pattern registers
    localparam int WORD_W          = 64;  // width of one pattern word register
    localparam int NUM_WORDS       = 4;
    localparam int LEN_W           = 6;   // width of the pattern length register
    localparam int CFG_IDX_W       = 3;
    localparam int MATCH_W         = 32;  // width of the reported start index
    localparam int DEF_MAX_PATTERN = 32;
    localparam int DEF_INDEX_BITS  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH = 3'd0,
        CFG_WORD0  = 3'd1,
        CFG_WORD1  = 3'd2,
        CFG_WORD2  = 3'd3,
        CFG_WORD3  = 3'd4
    } t_cfg_idx;

    // Pattern byte at position idx; positions past the registers read as zero.
    function automatic logic [7:0] pattern_byte(
        input logic [PATTERN_BYTES*8-1:0] flat,
        input logic [6:0]                 idx
    );
        logic [7:0] b;
        if (idx >= 7'(PATTERN_BYTES)) begin
            b = 8'h00;
        end else begin
            b = flat[{idx[4:0], 3'b000} +: 8];
        end
        return b;
    endfunction

endpackage

// ===== src/rsss_cfg.sv =====
// Pattern configuration registers and the aligned compare image of the pattern.
// Depends on rsss_pkg.
module rsss_cfg #(
    parameter int MAX_PATTERN = rsss_pkg::DEF_MAX_PATTERN,
    parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rsss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rsss_pkg::WORD_W-1:0]         i_cfg_wdata,
    output logic [LW-1:0]                       o_used_len,
    output logic [MAX_PATTERN*8-1:0]            o_pat,
    output logic [MAX_PATTERN-1:0]              o_mask
);

    localparam int CW = (LW > rsss_pkg::LEN_W) ? LW : rsss_pkg::LEN_W;

    logic [rsss_pkg::LEN_W-1:0]  r_length;
    logic [rsss_pkg::WORD_W-1:0] r_words [rsss_pkg::NUM_WORDS];

    logic [rsss_pkg::PATTERN_BYTES*8-1:0] flat;
    logic [LW-1:0]                        n_used;
    logic [MAX_PATTERN*8-1:0]             n_pat;
    logic [MAX_PATTERN-1:0]               n_mask;

    logic [LW-1:0]            r_used;
    logic [MAX_PATTERN*8-1:0] r_pat;
    logic [MAX_PATTERN-1:0]   r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            for (int w = 0; w < rsss_pkg::NUM_WORDS; w++) begin
                r_words[w] <= '0;
            end
        end else if (i_cfg_we) begin
            case (rsss_pkg::t_cfg_idx'(i_cfg_idx))
                rsss_pkg::CFG_LENGTH: r_length   <= i_cfg_wdata[rsss_pkg::LEN_W-1:0];
                rsss_pkg::CFG_WORD0:  r_words[0] <= i_cfg_wdata;
                rsss_pkg::CFG_WORD1:  r_words[1] <= i_cfg_wdata;
                rsss_pkg::CFG_WORD2:  r_words[2] <= i_cfg_wdata;
                rsss_pkg::CFG_WORD3:  r_words[3] <= i_cfg_wdata;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    assign flat = {r_words[3], r_words[2], r_words[1], r_words[0]};

    // Clamp the length, then reverse the pattern so that window entry k
    // (k = 0 newest) lines up with pattern byte used-1-k.
    always_comb begin
        logic [LW-1:0] j;
        if (CW'(r_length) > CW'(MAX_PATTERN)) begin
            n_used = LW'(MAX_PATTERN);
        end else begin
            n_used = LW'(r_length);
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            j = n_used - LW'(k) - LW'(1);
            if (LW'(k) < n_used) begin
                n_mask[k]        = 1'b1;
                n_pat[k*8 +: 8]  = rsss_pkg::pattern_byte(flat, 7'(j));
            end else begin
                n_mask[k]        = 1'b0;
                n_pat[k*8 +: 8]  = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_pat  <= '0;
            r_mask <= '0;
        end else begin
            r_used <= n_used;
            r_pat  <= n_pat;
            r_mask <= n_mask;
        end
    end

    assign o_used_len = r_used;
    assign o_pat      = r_pat;
    assign o_mask     = r_mask;

endmodule

// ===== src/rolling_sum_substring_search.sv =====
// Top level of the streaming first-occurrence substring search.
// Depends on rsss_pkg and rsss_cfg.
//
// Usage
//   Text bytes enter on the input channel (i_in_valid / o_in_stall), one
//   transfer per byte, with i_last marking the final byte of a text. For each
//   text exactly one result leaves on the output channel (o_out_valid /
//   i_out_stall): o_found and o_match_index, the start of the first
//   occurrence of the configured pattern, or zero when there is none.
//   The user must set the pattern via the write port (length, then four 64-bit
//   words, lowest byte first) while no text is in flight; the block has no check.
// Timing
//   One byte is taken every cycle unless a last byte waits on a stalled result.
//   A byte is registered at its transfer and checked in the following cycle
//   against all pattern positions in parallel; a last byte's result is
//   registered as that byte advances. The parallel window compare sets the
//   rate. A pattern write takes effect for bytes transferred from the next cycle.
// Reset and back-pressure
//   Reset (synchronous, active low) clears the pattern to empty, the byte
//   count and the match record. While a result waits under i_out_stall,
//   ordinary bytes keep flowing; only a further last byte is held, and the
//   input channel then stalls.
module rolling_sum_substring_search #(
    parameter int MAX_PATTERN = rsss_pkg::DEF_MAX_PATTERN,
    parameter int INDEX_BITS  = rsss_pkg::DEF_INDEX_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [rsss_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rsss_pkg::WORD_W-1:0]      i_cfg_wdata,
    // text input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_text_byte,
    input  logic                             i_last,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [rsss_pkg::MATCH_W-1:0]     o_match_index
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [INDEX_BITS-1:0] COUNT_MAX = '1;

    // aligned pattern image from the configuration block
    logic [LW-1:0]            used_len;
    logic [MAX_PATTERN*8-1:0] pat;
    logic [MAX_PATTERN-1:0]   mask;

    rsss_cfg #(
        .MAX_PATTERN (MAX_PATTERN),
        .LW          (LW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_used_len  (used_len),
        .o_pat       (pat),
        .o_mask      (mask)
    );

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // text state
    logic [7:0]            r_win [MAX_PATTERN];
    logic [INDEX_BITS-1:0] r_count;
    logic                  r_seen;
    logic [INDEX_BITS-1:0] r_start;

    // output register
    logic                         r_out_valid;
    logic                         r_found;
    logic [rsss_pkg::MATCH_W-1:0] r_index;

    logic                  in_xfer;
    logic                  out_free;
    logic                  advance;
    logic [7:0]            n_win [MAX_PATTERN];
    logic [INDEX_BITS-1:0] n_count;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic                  hit;
    logic                  n_seen;
    logic [INDEX_BITS-1:0] n_start;

    // A byte advances unless it is a last byte and the result slot is full.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_last;
        end
    end

    // Window after this byte: entry 0 is the newest byte. Compare every
    // position in use against the reversed pattern at once. Byte equality
    // over the window implies equal byte sums, so the sum pre-filter adds
    // nothing to the decision and is folded into the compare.
    always_comb begin
        n_win[0] = r_in_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
        for (int k = 0; k < MAX_PATTERN; k++) begin
            byte_ok[k] = !mask[k] || (n_win[k] == pat[k*8 +: 8]);
        end
    end

    // saturating byte count
    assign n_count = (r_count == COUNT_MAX) ? r_count : r_count + INDEX_BITS'(1);

    assign hit = (&byte_ok) && (n_count >= INDEX_BITS'(used_len));

    always_comb begin
        n_seen  = r_seen;
        n_start = r_start;
        if (!r_seen) begin
            if (used_len == '0) begin
                // empty pattern matches at the start of any text
                n_seen  = 1'b1;
                n_start = '0;
            end else if (hit) begin
                n_seen  = 1'b1;
                n_start = n_count - INDEX_BITS'(used_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // Advance the record; a last byte reports it and clears it for the next text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen  <= 1'b0;
            r_start <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_count <= '0;
                r_seen  <= 1'b0;
                r_start <= '0;
            end else begin
                r_count <= n_count;
                r_seen  <= n_seen;
                r_start <= n_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_found <= n_seen;
            r_index <= n_seen ? rsss_pkg::MATCH_W'(n_start) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_index;

    // A stalled result must never be overwritten by a new last byte.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(advance && r_in_last))
        else $error("result register overwritten while stalled");

    // A recorded match stays until its text ends.
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen && !(advance && r_in_last)) |=> r_seen)
        else $error("match record lost mid-text");

    // The end of a text clears the count and the record.
    a_text_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_count == '0 && !r_seen))
        else $error("text state not cleared after last byte");

    // A result without a match carries a zero index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_found) |-> (r_index == '0))
        else $error("non-zero index on a not-found result");

endmodule

// ===== tb/sv/tb_rolling_sum_substring_search.sv =====
// Self-checking testbench for rolling_sum_substring_search: directed texts, then
// random pattern phases with random texts, input gaps and result stalls.
// Depends on rsss_pkg and the block's RTL only.
module tb_rolling_sum_substring_search;
    timeunit 1ns;
    timeprecision 1ps;

    import rsss_pkg::*;

    localparam int MAX_PAT        = DEF_MAX_PATTERN;
    localparam int RANDOM_ITEMS   = 1450;
    localparam int QUIET_FROM     = 1200;  // no idling from here on
    localparam int SETTLE_CYCLES  = 4;     // wait after draining, for the last check to settle
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(CFG_WORD3 + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_beat;

    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] index;
    } t_search_hit;

    // DUT inputs, all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_LENGTH;
    logic [WORD_W-1:0]    i_cfg_wdata = '0;
    logic                 i_in_valid  = 1'b0;
    logic [7:0]           i_text_byte = '0;
    logic                 i_last      = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_found;
    logic [MATCH_W-1:0]   o_match_index;

    rolling_sum_substring_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_byte   (i_text_byte),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_match_index (o_match_index)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Search predictor: its own copy of the pattern registers and of the
    // per-text state (byte window, newest first; byte count; match record).
    // ------------------------------------------------------------------
    logic [5:0]         pat_len = '0;
    logic [WORD_W-1:0]  pat_word [NUM_WORDS];
    logic [7:0]         window [MAX_PAT];
    logic [31:0]        text_count = '0;
    logic               hit_seen   = 1'b0;
    logic [31:0]        hit_start  = '0;
    t_search_hit        expected_hits [$];

    // Lengths above the window are clamped to the window.
    function automatic int unsigned active_len();
        return (pat_len > 6'(MAX_PAT)) ? MAX_PAT : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_byte_at(input int unsigned i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic clear_text_state();
        foreach (window[k]) window[k] = 8'h00;
        text_count = '0;
        hit_seen   = 1'b0;
        hit_start  = '0;
    endtask

    // Advance the predictor by one transferred byte; queue a result on last.
    task automatic search_step(input logic [7:0] b, input logic is_last);
        int unsigned n;
        logic [12:0] win_sum;
        logic [12:0] pat_sum;
        logic        same;
        t_search_hit hit;
        n = active_len();
        for (int k = MAX_PAT - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = b;
        if (text_count != '1) text_count = text_count + 1;
        // Both sums fit in 13 bits without wrapping; the sum only filters, the byte compare decides
        win_sum = '0;
        pat_sum = '0;
        for (int k = 0; k < n; k++) begin
            win_sum = win_sum + 13'(window[k]);
            pat_sum = pat_sum + 13'(pat_byte_at(k));
        end
        if (!hit_seen) begin
            if (n == 0) begin
                // empty pattern: found at the very first byte
                hit_seen  = 1'b1;
                hit_start = '0;
            end else if (text_count >= n && win_sum == pat_sum) begin
                same = 1'b1;
                for (int k = 0; k < n; k++) begin
                    if (window[n - 1 - k] != pat_byte_at(k)) same = 1'b0;
                end
                if (same) begin
                    hit_seen  = 1'b1;
                    hit_start = text_count - n;
                end
            end
        end
        if (is_last) begin
            hit.found = hit_seen;
            hit.index = hit_seen ? hit_start : '0;
            expected_hits.insert(expected_hits.size(), hit);
            clear_text_state();
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: transfer bytes from pending_bytes, with random gaps
    // ------------------------------------------------------------------
    t_text_beat  pending_bytes [$];
    int unsigned bytes_issued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;
    bit          idle_on      = 1'b1;

    always @(negedge i_clk) begin
        t_text_beat beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || bytes_taken == bytes_issued) begin
            // Current byte gone (or none held): idle out a gap or load the next one
            if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
                beat = pending_bytes.pop_front();
                i_text_byte <= beat.data;
                i_last      <= beat.last;
                i_in_valid  <= 1'b1;
                bytes_issued = bytes_issued + 1;
                if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // otherwise hold valid and payload until the transfer
    end

    // Receiver: stall the result channel in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && i_rst_n && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each byte transfer, check each result transfer
    // ------------------------------------------------------------------
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_search_hit want;
        logic        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                search_step(i_text_byte, i_last);
                bytes_taken = bytes_taken + 1;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_hits.size() == 0) begin
                    flag_mismatch("result with nothing outstanding, index", '0, o_match_index);
                end else begin
                    want = expected_hits.pop_front();
                    if (o_found !== want.found)
                        flag_mismatch("found", 32'(want.found), 32'(o_found));
                    if (o_match_index !== want.index)
                        flag_mismatch("match_index", want.index, o_match_index);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_rolling_sum_substring_search: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [7:0]  text_buf [$];
    int unsigned queued_items = 0;

    // Wait until every byte has gone and every result is back,
    // then let the last byte's check settle.
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || bytes_taken != bytes_issued ||
               expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Queue text_buf as one text, last flag on its final byte.
    task automatic flush_text();
        t_text_beat beat;
        foreach (text_buf[i]) begin
            beat.data = text_buf[i];
            beat.last = (i == text_buf.size() - 1);
            pending_bytes.insert(pending_bytes.size(), beat);
        end
        queued_items = queued_items + text_buf.size();
        text_buf.delete();
    endtask

    // One register write; the write enable stays up until end_writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        if (idx == CFG_LENGTH)
            pat_len = data[LEN_W-1:0];
        else if (idx >= CFG_WORD0 && idx <= CFG_WORD3)
            pat_word[idx - CFG_WORD0] = data;
        // any other index is dropped by the block
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Drain, then write length (junk above bit 5), all four words and
    // sometimes a register index past the list.
    task automatic program_pattern(input int unsigned len, input logic [WORD_W-1:0] w0,
                                   input logic [WORD_W-1:0] w1, input logic [WORD_W-1:0] w2,
                                   input logic [WORD_W-1:0] w3);
        logic [WORD_W-1:0] len_data;
        wait_drained();
        len_data = {$urandom, $urandom};
        len_data[LEN_W-1:0] = LEN_W'(len);
        write_reg(CFG_LENGTH, len_data);
        write_reg(CFG_WORD0, w0);
        write_reg(CFG_WORD1, w1);
        write_reg(CFG_WORD2, w2);
        write_reg(CFG_WORD3, w3);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_IDX, (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
        end_writes();
    endtask

    // Mostly pattern bytes so that near misses and overlaps are common.
    function automatic logic [7:0] noise_byte(input int unsigned u);
        if (u != 0 && $urandom_range(0, 2) != 0)
            return pat_byte_at($urandom_range(0, u - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    // Build and queue one random text against the current pattern.
    task automatic make_text();
        int unsigned u;
        int unsigned kind;
        int unsigned cut;
        int unsigned a;
        int unsigned c;
        logic [7:0]  pat_copy [$];
        logic [7:0]  tmp;
        u = active_len();
        for (int i = 0; i < u; i++) pat_copy.insert(pat_copy.size(), pat_byte_at(i));
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            // plain noise
            repeat ($urandom_range(1, 24)) text_buf.insert(text_buf.size(), noise_byte(u));
        end else if (kind == 1) begin
            // shorter than the pattern: a prefix of it (one noise byte for patterns under two bytes)
            cut = (u > 1) ? $urandom_range(1, u - 1) : 1;
            for (int i = 0; i < cut; i++)
                text_buf.insert(text_buf.size(), (u > 1) ? pat_copy[i] : noise_byte(u));
        end else begin
            if (kind == 2 && u != 0) begin
                // broken copy: a swap keeps the sum, a bumped byte does not
                a = $urandom_range(0, u - 1);
                if (u >= 2 && $urandom_range(0, 1) == 1) begin
                    c = $urandom_range(0, u - 1);
                    tmp         = pat_copy[a];
                    pat_copy[a] = pat_copy[c];
                    pat_copy[c] = tmp;
                end else begin
                    pat_copy[a] = pat_copy[a] + 8'd1;
                end
            end
            repeat ($urandom_range(0, 10)) text_buf.insert(text_buf.size(), noise_byte(u));
            foreach (pat_copy[i]) text_buf.insert(text_buf.size(), pat_copy[i]);
            // bytes after a match must not move the record
            repeat ($urandom_range(0, 6)) text_buf.insert(text_buf.size(), noise_byte(u));
            if ($urandom_range(0, 3) == 0)
                foreach (pat_copy[i]) text_buf.insert(text_buf.size(), pat_copy[i]);
        end
        if (text_buf.size() == 0) text_buf.insert(0, noise_byte(u));
        flush_text();
    endtask

    // Pattern for one random phase; the first few phases pin the extremes.
    task automatic random_pattern(input int unsigned phase);
        logic [WORD_W-1:0] words [NUM_WORDS];
        logic [7:0]        v0;
        logic [7:0]        v1;
        int unsigned       len;
        int unsigned       r;
        bit                two_vals;
        v0 = 8'($urandom);
        v1 = 8'($urandom);
        two_vals = $urandom_range(0, 1);
        foreach (words[w])
            for (int k = 0; k < 8; k++)
                words[w][8 * k +: 8] = two_vals ? ($urandom_range(0, 1) ? v0 : v1)
                                                : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 15);
        if (r == 0)      len = 0;
        else if (r == 1) len = $urandom_range(MAX_PAT + 1, (1 << LEN_W) - 1);
        else if (r <= 4) len = $urandom_range(17, MAX_PAT);
        else if (r <= 9) len = $urandom_range(5, 16);
        else             len = $urandom_range(1, 4);
        case (phase)
            0: begin
                len = MAX_PAT;
                foreach (words[w]) words[w] = '1;
            end
            1: begin
                len = (1 << LEN_W) - 1;
                foreach (words[w]) words[w] = '0;
            end
            2: len = 0;
            3: len = 1;
            default: ;
        endcase
        program_pattern(len, words[0], words[1], words[2], words[3]);
    endtask

    initial begin : stimulus
        int unsigned phase;
        int unsigned budget;
        t_text_beat  beat;
        foreach (pat_word[w]) pat_word[w] = '0;
        clear_text_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pattern straight out of reset: found at index 0
        text_buf = '{8'h00};
        flush_text();
        text_buf = '{8'hFF, 8'h5A};
        flush_text();

        // Three-byte pattern FF 00 80
        program_pattern(3, {$urandom, 8'h5C, 24'h8000FF}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
        // index past the list must not touch word 0
        write_reg(FIRST_UNUSED_IDX, '0);
        end_writes();
        // short text: not found
        text_buf = '{8'hFF, 8'h00};
        flush_text();
        // same-sum permutation first, real match at 3, later copy ignored
        text_buf = '{8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h11, 8'hFF, 8'h00, 8'h80};
        flush_text();

        // Pattern change in the middle of a text applies from the next byte
        program_pattern(2, {48'h0, 16'h3412}, '0, '0, '0);
        beat.data = 8'h12;
        beat.last = 1'b0;
        pending_bytes.insert(pending_bytes.size(), beat);
        program_pattern(1, {56'h0, 8'h34}, '0, '0, '0);
        text_buf = '{8'h34};
        flush_text();

        // Random phases; each pattern write first drains every result
        queued_items = 0;
        phase = 0;
        while (queued_items < RANDOM_ITEMS) begin
            if (queued_items >= QUIET_FROM) idle_on = 1'b0;
            random_pattern(phase);
            budget = queued_items + $urandom_range(60, 140);
            if (budget > RANDOM_ITEMS) budget = RANDOM_ITEMS;
            while (queued_items < budget) make_text();
            phase = phase + 1;
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        while (expected_hits.size() != 0) begin
            flag_mismatch("result never arrived, index", expected_hits[0].index, '0);
            void'(expected_hits.pop_front());
        end
        if (mismatches == 0) begin
            $display("tb_rolling_sum_substring_search: PASS");
        end else begin
            $display("tb_rolling_sum_substring_search: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rsss_pkg.sv
src/rsss_cfg.sv
src/rolling_sum_substring_search.sv
tb/sv/tb_rolling_sum_substring_search.sv
